[sv/ptgs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptgs_pkg
// shared constants, command codes and transaction types of the tile grid store
// ----------------------------------------------------------------------------
package ptgs_pkg;

  localparam int MAP_ROWS  = 32;
  localparam int GRID_COLS = 64;
  localparam int COL_W     = 6;
  localparam int ROW_W     = (MAP_ROWS > 1) ? $clog2(MAP_ROWS) : 1;
  localparam int ADDR_W    = ROW_W + COL_W;
  localparam int DEPTH     = GRID_COLS * MAP_ROWS;
  localparam int TILE_W    = 3;

  localparam logic [7:0]        ROWS8     = 8'(MAP_ROWS);
  localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(MAP_ROWS - 1);
  localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(GRID_COLS - 1);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

  localparam logic [2:0] CMD_READ  = 3'd0;
  localparam logic [2:0] CMD_WRITE = 3'd1;
  localparam logic [2:0] CMD_TEST  = 3'd2;
  localparam logic [2:0] CMD_NEIGH = 3'd3;
  localparam logic [2:0] CMD_CLEAR = 3'd4;

  localparam logic [2:0] CODE_EMPTY = 3'd0;
  localparam logic [2:0] CODE_WALL  = 3'd1;
  localparam logic [2:0] CODE_FLOOR = 3'd2;
  localparam logic [2:0] CODE_DOOR  = 3'd3;

  localparam logic [3:0] CLASS_EMPTY = 4'h1;
  localparam logic [3:0] CLASS_WALL  = 4'h2;
  localparam logic [3:0] CLASS_FLOOR = 4'h4;
  localparam logic [3:0] CLASS_DOOR  = 4'h8;

  localparam int CMD_W    = 27;
  localparam int IN_TD_W  = 32;
  localparam int OUT_TD_W = 8;

  typedef struct packed {
    logic             diag_en;
    logic [3:0]       class_mask;
    logic [2:0]       tile;
    logic [7:0]       y;
    logic [7:0]       x;
    logic [2:0]       cmd;
  } cmd_t;

  typedef struct packed {
    logic              valid;
    logic [TILE_W-1:0] tile_value;
    logic              found;
  } res_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [TILE_W-1:0] wdata;
  } ram_req_t;

endpackage
`default_nettype wire

[sv/ptgs_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptgs_ram
// single-port synchronous ram, read data registered
// ----------------------------------------------------------------------------
module ptgs_ram #(
  parameter int DATA_W = 3,
  parameter int ADDR_W = 11,
  parameter int DEPTH  = 2048
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] addr,
  input  wire logic [DATA_W-1:0] wdata,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

[sv/ptgs_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptgs_ctrl
// command sequencer: access, neighbor scan and clear sweep over the tile ram
// ----------------------------------------------------------------------------
module ptgs_ctrl (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cmd_valid,
  input  wire ptgs_pkg::cmd_t            cmd,
  output logic                           cmd_ready,
  input  wire logic                      res_ready,
  output ptgs_pkg::res_t                 res,
  output ptgs_pkg::ram_req_t             ram_req,
  input  wire logic [ptgs_pkg::TILE_W-1:0] ram_rdata
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RD   = 3'd1;
  localparam logic [2:0] ST_NB   = 3'd2;
  localparam logic [2:0] ST_CLR  = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  localparam logic [3:0] NB_N  = 4'd0;
  localparam logic [3:0] NB_S  = 4'd1;
  localparam logic [3:0] NB_W  = 4'd2;
  localparam logic [3:0] NB_E  = 4'd3;
  localparam logic [3:0] NB_NW = 4'd4;
  localparam logic [3:0] NB_NE = 4'd5;
  localparam logic [3:0] NB_SW = 4'd6;
  localparam logic [3:0] NB_SE = 4'd7;
  localparam logic [3:0] NB_ORTHO = 4'd4;
  localparam logic [3:0] NB_ALL   = 4'd8;

  function automatic logic class_hit(input logic [2:0] code, input logic [3:0] flags);
    logic [3:0] cls;
    case (code)
      ptgs_pkg::CODE_EMPTY: cls = ptgs_pkg::CLASS_EMPTY;
      ptgs_pkg::CODE_WALL:  cls = ptgs_pkg::CLASS_WALL;
      ptgs_pkg::CODE_FLOOR: cls = ptgs_pkg::CLASS_FLOOR;
      ptgs_pkg::CODE_DOOR:  cls = ptgs_pkg::CLASS_DOOR;
      default:              cls = 4'h0;
    endcase
    return (cls & flags) != 4'h0;
  endfunction

  logic [2:0]                      state_r, state_nxt;
  logic [2:0]                      op_r, op_nxt;
  logic [ptgs_pkg::COL_W-1:0]      x_r, x_nxt;
  logic [ptgs_pkg::ROW_W-1:0]      y_r, y_nxt;
  logic [3:0]                      flags_r, flags_nxt;
  logic                            diag_r, diag_nxt;
  logic [3:0]                      k_r, k_nxt;
  logic                            pend_r, pend_nxt;
  logic [ptgs_pkg::ADDR_W-1:0]     clr_addr_r, clr_addr_nxt;
  logic                            clr_res_r, clr_res_nxt;
  logic [ptgs_pkg::TILE_W-1:0]     tv_r, tv_nxt;
  logic                            found_r, found_nxt;

  logic                            in_b;
  logic                            go_n, go_s, go_w, go_e;
  logic                            nb_ok, nb_hit, k_end;
  logic [ptgs_pkg::COL_W-1:0]      nx;
  logic [ptgs_pkg::ROW_W-1:0]      ny;

  // neighbor direction decode
  always_comb begin
    go_n = (k_r == NB_N) || (k_r == NB_NW) || (k_r == NB_NE);
    go_s = (k_r == NB_S) || (k_r == NB_SW) || (k_r == NB_SE);
    go_w = (k_r == NB_W) || (k_r == NB_NW) || (k_r == NB_SW);
    go_e = (k_r == NB_E) || (k_r == NB_NE) || (k_r == NB_SE);
    nb_ok = !(go_w && (x_r == '0)) && !(go_e && (x_r == ptgs_pkg::LAST_COL)) &&
            !(go_n && (y_r == '0)) && !(go_s && (y_r == ptgs_pkg::LAST_ROW));
    nx = x_r + ptgs_pkg::COL_W'(go_e) - ptgs_pkg::COL_W'(go_w);
    ny = y_r + ptgs_pkg::ROW_W'(go_s) - ptgs_pkg::ROW_W'(go_n);
    k_end  = (k_r == (diag_r ? NB_ALL : NB_ORTHO));
    nb_hit = pend_r && class_hit(ram_rdata, flags_r);
    in_b   = (cmd.x[7:6] == 2'b00) && (cmd.y < ptgs_pkg::ROWS8);
  end

  always_comb begin
    state_nxt    = state_r;
    op_nxt       = op_r;
    x_nxt        = x_r;
    y_nxt        = y_r;
    flags_nxt    = flags_r;
    diag_nxt     = diag_r;
    k_nxt        = k_r;
    pend_nxt     = pend_r;
    clr_addr_nxt = clr_addr_r;
    clr_res_nxt  = clr_res_r;
    tv_nxt       = tv_r;
    found_nxt    = found_r;
    ram_req      = '0;
    cmd_ready    = (state_r == ST_IDLE);
    res.valid      = (state_r == ST_DONE);
    res.tile_value = tv_r;
    res.found      = found_r;

    case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          op_nxt    = cmd.cmd;
          x_nxt     = cmd.x[ptgs_pkg::COL_W-1:0];
          y_nxt     = cmd.y[ptgs_pkg::ROW_W-1:0];
          flags_nxt = cmd.class_mask;
          diag_nxt  = cmd.diag_en;
          k_nxt     = '0;
          pend_nxt  = 1'b0;
          tv_nxt    = '0;
          found_nxt = 1'b0;
          ram_req.addr  = {cmd.y[ptgs_pkg::ROW_W-1:0], cmd.x[ptgs_pkg::COL_W-1:0]};
          ram_req.wdata = cmd.tile;
          case (cmd.cmd)
            ptgs_pkg::CMD_READ, ptgs_pkg::CMD_TEST: begin
              state_nxt = in_b ? ST_RD : ST_DONE;
            end
            ptgs_pkg::CMD_WRITE: begin
              ram_req.we = in_b;
              state_nxt  = ST_DONE;
            end
            ptgs_pkg::CMD_NEIGH: begin
              state_nxt = in_b ? ST_NB : ST_DONE;
            end
            ptgs_pkg::CMD_CLEAR: begin
              clr_addr_nxt = '0;
              clr_res_nxt  = 1'b1;
              state_nxt    = ST_CLR;
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end
      ST_RD: begin
        if (op_r == ptgs_pkg::CMD_READ) begin
          tv_nxt = ram_rdata;
        end else begin
          found_nxt = class_hit(ram_rdata, flags_r);
        end
        state_nxt = ST_DONE;
      end
      ST_NB: begin
        if (nb_hit || k_end) begin
          found_nxt = nb_hit;
          pend_nxt  = 1'b0;
          state_nxt = ST_DONE;
        end else begin
          ram_req.addr = {ny, nx};
          pend_nxt     = nb_ok;
          k_nxt        = k_r + 4'd1;
        end
      end
      ST_CLR: begin
        ram_req.we    = 1'b1;
        ram_req.addr  = clr_addr_r;
        ram_req.wdata = '0;
        if (clr_addr_r == ptgs_pkg::LAST_ADDR) begin
          state_nxt = clr_res_r ? ST_DONE : ST_IDLE;
        end else begin
          clr_addr_nxt = clr_addr_r + ptgs_pkg::ADDR_W'(1);
        end
      end
      ST_DONE: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLR;
      clr_addr_r <= '0;
      clr_res_r  <= 1'b0;
      pend_r     <= 1'b0;
      k_r        <= '0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
      clr_res_r  <= clr_res_nxt;
      pend_r     <= pend_nxt;
      k_r        <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    x_r     <= x_nxt;
    y_r     <= y_nxt;
    flags_r <= flags_nxt;
    diag_r  <= diag_nxt;
    tv_r    <= tv_nxt;
    found_r <= found_nxt;
  end

  a_we_state: assert property (@(posedge clk) disable iff (!rst_n)
    ram_req.we |-> (state_r == ST_IDLE || state_r == ST_CLR))
    else $error("ram write outside idle or clear sweep");

  a_clr_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLR && clr_addr_r == ptgs_pkg::LAST_ADDR) |=>
    (state_r == ST_DONE || state_r == ST_IDLE))
    else $error("clear sweep did not finish");

  a_k_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_NB) |-> (k_r <= NB_ALL))
    else $error("neighbor index past last direction");

  a_pend_src: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> ($past(state_r) == ST_NB))
    else $error("pending neighbor read without scan");

endmodule
`default_nettype wire

[sv/packed_tile_grid_store.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// packed_tile_grid_store
// 64 x MAP_ROWS grid of 3-bit tile codes with read, write, type test,
// neighbor check and clear
//
// channel  dir  tdata fields (low bit first)
// in_      in   cmd[2:0] x[10:3] y[18:11] tile[21:19] class_mask[25:22]
//                diag_en[26], zero pad to 32
// out_     out  tile_value[2:0] found[3], zero pad to 8
//
// neighbor check: one ram read per neighbor through the single ram port
// clear: sweeps all 64*MAP_ROWS ram entries, one ram entry per sweep cycle
// after reset the same clearing pass runs with in_tready low
// a finished result waits in the output register while the next
// transaction is accepted
// ----------------------------------------------------------------------------
module packed_tile_grid_store (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // cmd, x, y, tile, class_mask, diag_en
  input  wire logic [ptgs_pkg::IN_TD_W-1:0]    in_tdata,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // tile_value, found
  output logic      [ptgs_pkg::OUT_TD_W-1:0]   out_tdata
);

  ptgs_pkg::cmd_t                  cmd;
  ptgs_pkg::res_t                  res;
  ptgs_pkg::ram_req_t              ram_req;
  logic [ptgs_pkg::TILE_W-1:0]     ram_rdata;
  logic                            res_ready;
  logic                            out_valid_r;
  logic [ptgs_pkg::TILE_W:0]       out_data_r;

  assign cmd       = ptgs_pkg::cmd_t'(in_tdata[ptgs_pkg::CMD_W-1:0]);
  assign res_ready = !out_valid_r || out_tready;

  ptgs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (in_tvalid),
    .cmd       (cmd),
    .cmd_ready (in_tready),
    .res_ready (res_ready),
    .res       (res),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata)
  );

  ptgs_ram #(
    .DATA_W (ptgs_pkg::TILE_W),
    .ADDR_W (ptgs_pkg::ADDR_W),
    .DEPTH  (ptgs_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .addr  (ram_req.addr),
    .wdata (ram_req.wdata),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid && res_ready) begin
      out_data_r <= {res.found, res.tile_value};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(ptgs_pkg::OUT_TD_W - ptgs_pkg::TILE_W - 1)'(0), out_data_r};

endmodule
`default_nettype wire

[bench/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the tile grid store: stream commands in, keep a
// shadow copy of the grid, predict each result and compare it on arrival
// ----------------------------------------------------------------------------
module testbench;

  localparam int         GRID_COLS   = ptgs_pkg::GRID_COLS;
  localparam int         MAP_ROWS    = ptgs_pkg::MAP_ROWS;
  localparam logic [2:0] CMD_READ    = ptgs_pkg::CMD_READ;
  localparam logic [2:0] CMD_WRITE   = ptgs_pkg::CMD_WRITE;
  localparam logic [2:0] CMD_TEST    = ptgs_pkg::CMD_TEST;
  localparam logic [2:0] CMD_NEIGH   = ptgs_pkg::CMD_NEIGH;
  localparam logic [2:0] CMD_CLEAR   = ptgs_pkg::CMD_CLEAR;
  localparam logic [2:0] CODE_EMPTY  = ptgs_pkg::CODE_EMPTY;
  localparam logic [2:0] CODE_WALL   = ptgs_pkg::CODE_WALL;
  localparam logic [2:0] CODE_FLOOR  = ptgs_pkg::CODE_FLOOR;
  localparam logic [2:0] CODE_DOOR   = ptgs_pkg::CODE_DOOR;
  localparam logic [3:0] CLASS_EMPTY = ptgs_pkg::CLASS_EMPTY;
  localparam logic [3:0] CLASS_WALL  = ptgs_pkg::CLASS_WALL;
  localparam logic [3:0] CLASS_FLOOR = ptgs_pkg::CLASS_FLOOR;
  localparam logic [3:0] CLASS_DOOR  = ptgs_pkg::CLASS_DOOR;
  localparam logic [7:0] ROWS8       = ptgs_pkg::ROWS8;

  localparam logic [2:0] TILE_ODD7  = 3'd7;
  localparam logic [2:0] CMD_SPARE5 = 3'd5;
  localparam logic [2:0] CMD_SPARE6 = 3'd6;
  localparam logic [2:0] CMD_SPARE7 = 3'd7;
  localparam logic [7:0] X_OUT      = 8'(GRID_COLS);
  localparam logic [7:0] X_LAST     = 8'(GRID_COLS - 1);
  localparam logic [7:0] Y_LAST     = 8'(MAP_ROWS - 1);
  localparam logic [7:0] COORD_MAX  = 8'hff;

  typedef struct packed {
    logic [2:0] tile_value;
    logic       found;
  } tile_res_t;

  logic                          clk;
  logic                          rst_n      = 1'b0;
  logic                          in_tvalid  = 1'b0;
  logic                          in_tready;
  logic [ptgs_pkg::IN_TD_W-1:0]  in_tdata   = '0;
  logic                          out_tvalid;
  logic                          out_tready = 1'b0;
  logic [ptgs_pkg::OUT_TD_W-1:0] out_tdata;

  logic [2:0]   tile_mem [GRID_COLS*MAP_ROWS];
  tile_res_t    expected_q [$];
  int           fail_cnt        = 0;
  int           sink_hold_left  = 0;
  bit           src_idle_on     = 1'b1;
  bit           sink_idle_on    = 1'b1;

  packed_tile_grid_store dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // grid shadow model
  function automatic logic [3:0] class_bits(logic [2:0] code);
    case (code)
      CODE_EMPTY: return CLASS_EMPTY;
      CODE_WALL:  return CLASS_WALL;
      CODE_FLOOR: return CLASS_FLOOR;
      CODE_DOOR:  return CLASS_DOOR;
      default:    return 4'h0;
    endcase
  endfunction

  function automatic bit on_grid(int cx, int cy);
    return cx >= 0 && cy >= 0 && cx < GRID_COLS && cy < MAP_ROWS;
  endfunction

  function automatic logic cell_hit(int cx, int cy, logic [3:0] mask);
    if (!on_grid(cx, cy)) return 1'b0;
    return (class_bits(tile_mem[cy*GRID_COLS + cx]) & mask) != 4'h0;
  endfunction

  function automatic logic near_hit(int cx, int cy, logic [3:0] mask, logic diag);
    int ddx [8] = '{0, 0, -1, 1, -1, 1, -1, 1};
    int ddy [8] = '{-1, 1, 0, 0, -1, -1, 1, 1};
    int lim;
    if (!on_grid(cx, cy)) return 1'b0;
    lim = diag ? 8 : 4;
    for (int k = 0; k < lim; k++)
      if (cell_hit(cx + ddx[k], cy + ddy[k], mask)) return 1'b1;
    return 1'b0;
  endfunction

  function automatic tile_res_t grid_apply(ptgs_pkg::cmd_t c);
    tile_res_t r;
    int        cx;
    int        cy;
    r  = '0;
    cx = int'(c.x);
    cy = int'(c.y);
    case (c.cmd)
      CMD_READ:  if (on_grid(cx, cy)) r.tile_value = tile_mem[cy*GRID_COLS + cx];
      CMD_WRITE: if (on_grid(cx, cy)) tile_mem[cy*GRID_COLS + cx] = c.tile;
      CMD_TEST:  r.found = cell_hit(cx, cy, c.class_mask);
      CMD_NEIGH: r.found = near_hit(cx, cy, c.class_mask, c.diag_en);
      CMD_CLEAR: foreach (tile_mem[i]) tile_mem[i] = '0;
      default: ;
    endcase
    return r;
  endfunction

  function automatic ptgs_pkg::cmd_t mk_cmd(logic [2:0] op, logic [7:0] cx, logic [7:0] cy,
                                            logic [2:0] code, logic [3:0] mask, logic diag);
    ptgs_pkg::cmd_t c;
    c.cmd        = op;
    c.x          = cx;
    c.y          = cy;
    c.tile       = code;
    c.class_mask = mask;
    c.diag_en    = diag;
    return c;
  endfunction

  // mostly near the two corners so writes and neighbor checks interact
  function automatic void pick_cell(output logic [7:0] px, output logic [7:0] py);
    int r;
    int span;
    r    = $urandom_range(0, 99);
    span = (MAP_ROWS > 6) ? 5 : MAP_ROWS - 1;
    if (r < 40) begin
      px = 8'($urandom_range(0, 5));
      py = 8'($urandom_range(0, span));
    end else if (r < 60) begin
      px = 8'(GRID_COLS - 1 - $urandom_range(0, 5));
      py = 8'(MAP_ROWS - 1 - $urandom_range(0, span));
    end else if (r < 85) begin
      px = 8'($urandom_range(0, GRID_COLS - 1));
      py = 8'($urandom_range(0, MAP_ROWS - 1));
    end else begin
      px = 8'($urandom_range(0, 255));
      py = 8'($urandom_range(0, 255));
    end
  endfunction

  function automatic ptgs_pkg::cmd_t rand_cmd();
    ptgs_pkg::cmd_t c;
    int   r;
    logic [7:0] px;
    logic [7:0] py;
    r = $urandom_range(0, 999);
    pick_cell(px, py);
    c = mk_cmd(CMD_NEIGH, px, py, 3'($urandom_range(0, 7)),
               4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
    if (r < 5)        c.cmd = CMD_CLEAR;
    else if (r < 25)  c.cmd = 3'($urandom_range(CMD_SPARE5, CMD_SPARE7));
    else if (r < 350) c.cmd = CMD_WRITE;
    else if (r < 570) c.cmd = CMD_READ;
    else if (r < 750) c.cmd = CMD_TEST;
    return c;
  endfunction

  // one input transaction; called and returns at a falling edge
  task automatic send_cmd(ptgs_pkg::cmd_t c);
    while (src_idle_on && $urandom_range(0, 99) < 36) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= ptgs_pkg::IN_TD_W'(c);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_q.push_back(grid_apply(c));
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_idling(bit on);
    @(posedge clk);
    src_idle_on  = on;
    sink_idle_on = on;
    @(negedge clk);
  endtask

  // result side: random stalls plus an optional long hold-off
  initial begin
    forever begin
      @(negedge clk);
      if (sink_hold_left > 0) begin
        out_tready <= 1'b0;
        sink_hold_left--;
      end else if (sink_idle_on) begin
        out_tready <= ($urandom_range(0, 99) >= 36);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    tile_res_t exp_res;
    if (rst_n && out_tvalid === 1'b1 && out_tready) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result transaction, tdata %h", out_tdata);
        fail_cnt++;
      end else begin
        exp_res = expected_q.pop_front();
        if (out_tdata[2:0] !== exp_res.tile_value) begin
          $error("tile_value: expected %0d, got %0d", exp_res.tile_value, out_tdata[2:0]);
          fail_cnt++;
        end
        if (out_tdata[3] !== exp_res.found) begin
          $error("found: expected %0d, got %0d", exp_res.found, out_tdata[3]);
          fail_cnt++;
        end
      end
    end
  end

  task automatic test_out_of_bounds();
    send_cmd(mk_cmd(CMD_READ,  X_OUT, 8'd0,  CODE_EMPTY, 4'h0, 1'b0));
    send_cmd(mk_cmd(CMD_TEST,  8'd0,  ROWS8, CODE_EMPTY, CLASS_EMPTY, 1'b0));
    send_cmd(mk_cmd(CMD_TEST,  X_LAST, Y_LAST, CODE_EMPTY, CLASS_EMPTY, 1'b1));
    send_cmd(mk_cmd(CMD_WRITE, X_OUT, 8'd5,  CODE_DOOR, 4'h0, 1'b0));
    send_cmd(mk_cmd(CMD_WRITE, 8'd10, ROWS8, CODE_WALL, 4'h0, 1'b0));
    send_cmd(mk_cmd(CMD_READ,  8'd0,  8'd5,  CODE_EMPTY, 4'h0, 1'b0));
    send_cmd(mk_cmd(CMD_READ,  8'd10, 8'd0,  CODE_EMPTY, 4'h0, 1'b0));
    send_cmd(mk_cmd(CMD_NEIGH, COORD_MAX, COORD_MAX, TILE_ODD7, 4'hf, 1'b1));
  endtask

  task automatic test_write_read();
    send_cmd(mk_cmd(CMD_WRITE, X_LAST, Y_LAST, TILE_ODD7, 4'hf, 1'b1));
    send_cmd(mk_cmd(CMD_READ,  X_LAST, Y_LAST, CODE_EMPTY, 4'h0, 1'b0));
    send_cmd(mk_cmd(CMD_WRITE, 8'd0, 8'd0, CODE_FLOOR, 4'h0, 1'b0));
    send_cmd(mk_cmd(CMD_READ,  8'd0, 8'd0, CODE_EMPTY, 4'h0, 1'b0));
  endtask

  task automatic test_type_classes();
    send_cmd(mk_cmd(CMD_TEST, 8'd0, 8'd0, CODE_EMPTY, CLASS_FLOOR, 1'b0));
    send_cmd(mk_cmd(CMD_TEST, 8'd0, 8'd0, CODE_EMPTY, ~CLASS_FLOOR, 1'b0));
    send_cmd(mk_cmd(CMD_TEST, X_LAST, Y_LAST, CODE_EMPTY, 4'hf, 1'b0));
  endtask

  task automatic test_neighbors();
    send_cmd(mk_cmd(CMD_NEIGH, 8'd1, 8'd1, CODE_EMPTY, CLASS_FLOOR, 1'b0));
    send_cmd(mk_cmd(CMD_NEIGH, 8'd1, 8'd1, CODE_EMPTY, CLASS_FLOOR, 1'b1));
    send_cmd(mk_cmd(CMD_NEIGH, 8'd0, 8'd0, CODE_EMPTY, CLASS_FLOOR, 1'b1));
    send_cmd(mk_cmd(CMD_WRITE, X_LAST - 8'd1, Y_LAST, CODE_DOOR, 4'h0, 1'b0));
    send_cmd(mk_cmd(CMD_NEIGH, X_LAST, Y_LAST, CODE_EMPTY, CLASS_DOOR, 1'b0));
    send_cmd(mk_cmd(CMD_NEIGH, X_LAST, Y_LAST - 8'd1, CODE_EMPTY, CLASS_DOOR, 1'b1));
    send_cmd(mk_cmd(CMD_NEIGH, X_LAST, Y_LAST, CODE_EMPTY, CLASS_EMPTY, 1'b1));
  endtask

  task automatic test_spare_cmds();
    send_cmd(mk_cmd(CMD_SPARE5, 8'd0, 8'd0, CODE_WALL, 4'hf, 1'b1));
    send_cmd(mk_cmd(CMD_SPARE6, COORD_MAX, COORD_MAX, TILE_ODD7, 4'hf, 1'b1));
    send_cmd(mk_cmd(CMD_SPARE7, 8'd0, 8'd0, CODE_DOOR, CLASS_FLOOR, 1'b0));
    send_cmd(mk_cmd(CMD_READ,   8'd0, 8'd0, CODE_EMPTY, 4'h0, 1'b0));
  endtask

  task automatic test_clear();
    send_cmd(mk_cmd(CMD_CLEAR, 8'd0, 8'd0, CODE_EMPTY, 4'h0, 1'b0));
    send_cmd(mk_cmd(CMD_READ,  X_LAST, Y_LAST, CODE_EMPTY, 4'h0, 1'b0));
  endtask

  task automatic test_backpressure();
    drain_results();
    @(posedge clk);
    sink_hold_left = 400;
    @(negedge clk);
    repeat (16) send_cmd(rand_cmd());
    drain_results();
  endtask

  task automatic test_random_traffic(int n);
    for (int i = 0; i < n; i++) begin
      if (i == n / 3) set_idling(1'b0);
      if (i == n / 2) set_idling(1'b1);
      send_cmd(rand_cmd());
    end
  endtask

  initial begin
    foreach (tile_mem[i]) tile_mem[i] = '0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_out_of_bounds();
    test_write_read();
    test_type_classes();
    test_neighbors();
    test_spare_cmds();
    test_clear();
    test_backpressure();
    test_random_traffic(350);
    drain_results();
    repeat (24) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
